>>> design/lipm_pkg.sv
package lipm_pkg;

  // Default planning horizon.
  localparam int STEPS_DEF = 4;

  // Fixed-point word width (Q8.24).
  localparam int QW = 32;

  // Configuration register indexes.
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_COSH     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SINH     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TC       = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_INV_TC   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_INV_TCS  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_INV_DEN  = 3'd5;

  localparam logic [QW-1:0] Q_ONE = 32'h0100_0000;

  // Micro-program layout.
  localparam int PC_W = 5;
  localparam logic [PC_W-1:0] PC_TS         = 5'd0;
  localparam logic [PC_W-1:0] PC_INIT_FIRST = 5'd1;
  localparam logic [PC_W-1:0] PC_INIT_LAST  = 5'd2;
  localparam logic [PC_W-1:0] PC_AXIS_FIRST = 5'd3;
  localparam logic [PC_W-1:0] PC_AXIS_LAST  = 5'd22;

  // Multiplier operand sources.
  typedef enum logic [4:0] {
    SRC_C, SRC_S, SRC_TS, SRC_OMC, SRC_K, SRC_W10, SRC_TMP, SRC_TC,
    SRC_X0, SRC_V0, SRC_F0, SRC_ITC, SRC_ITS, SRC_IDN, SRC_P, SRC_XI,
    SRC_VI, SRC_E
  } src_t;

  // Accumulator update modes.
  typedef enum logic [2:0] {
    MODE_LD, MODE_ADD, MODE_SUB, MODE_KEEP, MODE_XE, MODE_FT
  } mode_t;

  // Destination of the new accumulator value.
  typedef enum logic [2:0] {
    DST_NONE, DST_TS, DST_V0, DST_XI, DST_VI, DST_E, DST_T2, DST_FT
  } dst_t;

  typedef struct packed {
    src_t  src_a;
    src_t  src_b;
    mode_t mode;
    dst_t  dst;
  } uop_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_TS, ST_INIT, ST_LEG, ST_AXIS, ST_EMIT
  } state_t;

  // Controller to datapath commands.
  typedef struct packed {
    logic load;
    logic issue;
    logic wb;
    logic leg;
    logic emit;
    logic axis;
    uop_t op;
  } cmd_t;

  // Datapath to controller status.
  typedef struct packed {
    logic slot_free;
    logic first;
  } status_t;

  // Micro-program store.
  function automatic uop_t uop_rom(input logic [PC_W-1:0] pc);
    uop_t u;
    u = '{SRC_C, SRC_X0, MODE_KEEP, DST_NONE};
    unique case (pc)
      5'd0:    u = '{SRC_TC,  SRC_S,   MODE_LD,   DST_TS};
      5'd1:    u = '{SRC_K,   SRC_F0,  MODE_KEEP, DST_NONE};
      5'd2:    u = '{SRC_TMP, SRC_ITS, MODE_LD,   DST_V0};
      5'd3:    u = '{SRC_C,   SRC_X0,  MODE_LD,   DST_NONE};
      5'd4:    u = '{SRC_TS,  SRC_V0,  MODE_ADD,  DST_NONE};
      5'd5:    u = '{SRC_OMC, SRC_F0,  MODE_ADD,  DST_XI};
      5'd6:    u = '{SRC_S,   SRC_X0,  MODE_KEEP, DST_NONE};
      5'd7:    u = '{SRC_TMP, SRC_ITC, MODE_LD,   DST_NONE};
      5'd8:    u = '{SRC_C,   SRC_V0,  MODE_ADD,  DST_NONE};
      5'd9:    u = '{SRC_S,   SRC_F0,  MODE_KEEP, DST_NONE};
      5'd10:   u = '{SRC_TMP, SRC_ITC, MODE_SUB,  DST_VI};
      5'd11:   u = '{SRC_K,   SRC_P,   MODE_KEEP, DST_NONE};
      5'd12:   u = '{SRC_TMP, SRC_ITS, MODE_LD,   DST_NONE};
      5'd13:   u = '{SRC_S,   SRC_XI,  MODE_KEEP, DST_NONE};
      5'd14:   u = '{SRC_TMP, SRC_ITC, MODE_SUB,  DST_NONE};
      5'd15:   u = '{SRC_C,   SRC_VI,  MODE_SUB,  DST_E};
      5'd16:   u = '{SRC_S,   SRC_E,   MODE_KEEP, DST_NONE};
      5'd17:   u = '{SRC_TMP, SRC_ITC, MODE_KEEP, DST_NONE};
      5'd18:   u = '{SRC_TMP, SRC_IDN, MODE_LD,   DST_T2};
      5'd19:   u = '{SRC_C,   SRC_XI,  MODE_XE,   DST_NONE};
      5'd20:   u = '{SRC_TS,  SRC_VI,  MODE_SUB,  DST_E};
      5'd21:   u = '{SRC_W10, SRC_E,   MODE_KEEP, DST_NONE};
      5'd22:   u = '{SRC_TMP, SRC_IDN, MODE_FT,   DST_FT};
      default: u = '{SRC_C,   SRC_X0,  MODE_KEEP, DST_NONE};
    endcase
    return u;
  endfunction

  // Product of +0.5 and a value, rounded toward minus infinity.
  function automatic logic [QW-1:0] half_pos(input logic [QW-1:0] v);
    return {v[QW-1], v[QW-1:1]};
  endfunction

  // Product of -0.5 and a value, rounded toward minus infinity.
  function automatic logic [QW-1:0] half_neg(input logic [QW-1:0] v);
    logic [QW:0] n;
    n = (QW+1)'(0) - {v[QW-1], v};
    return n[QW:1];
  endfunction

endpackage

>>> design/lipm_ctrl.sv
module lipm_ctrl #(
  parameter int STEPS = lipm_pkg::STEPS_DEF,
  localparam int NW = $clog2(STEPS + 1)
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  lipm_pkg::status_t  status,
  output lipm_pkg::cmd_t     cmd,
  output logic [NW-1:0]      step_n
);

  lipm_pkg::state_t            state_r, state_nxt;
  logic [lipm_pkg::PC_W-1:0]   pc_r, pc_nxt;
  logic                        phase_r, phase_nxt;
  logic                        axis_r, axis_nxt;
  logic [NW-1:0]               n_r, n_nxt;

  // State and sequencing registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= lipm_pkg::ST_IDLE;
      pc_r    <= '0;
      phase_r <= 1'b0;
      axis_r  <= 1'b0;
      n_r     <= NW'(1);
    end else begin
      state_r <= state_nxt;
      pc_r    <= pc_nxt;
      phase_r <= phase_nxt;
      axis_r  <= axis_nxt;
      n_r     <= n_nxt;
    end
  end

  // Next state and commands.
  always_comb begin
    state_nxt = state_r;
    pc_nxt    = pc_r;
    phase_nxt = phase_r;
    axis_nxt  = axis_r;
    n_nxt     = n_r;
    in_ready  = 1'b0;
    cmd       = '0;
    cmd.axis  = axis_r;
    cmd.op    = lipm_pkg::uop_rom(pc_r);
    unique case (state_r)
      lipm_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = lipm_pkg::ST_TS;
          pc_nxt    = lipm_pkg::PC_TS;
          phase_nxt = 1'b0;
          n_nxt     = NW'(1);
        end
      end
      lipm_pkg::ST_TS: begin
        cmd.issue = !phase_r;
        cmd.wb    = phase_r;
        phase_nxt = !phase_r;
        if (phase_r) begin
          if (status.first) begin
            state_nxt = lipm_pkg::ST_INIT;
            pc_nxt    = lipm_pkg::PC_INIT_FIRST;
            axis_nxt  = 1'b1;
          end else begin
            state_nxt = lipm_pkg::ST_LEG;
          end
        end
      end
      lipm_pkg::ST_INIT: begin
        cmd.issue = !phase_r;
        cmd.wb    = phase_r;
        phase_nxt = !phase_r;
        if (phase_r) begin
          if (pc_r == lipm_pkg::PC_INIT_LAST) begin
            state_nxt = lipm_pkg::ST_LEG;
          end else begin
            pc_nxt = pc_r + 1'b1;
          end
        end
      end
      lipm_pkg::ST_LEG: begin
        cmd.leg   = 1'b1;
        axis_nxt  = 1'b0;
        pc_nxt    = lipm_pkg::PC_AXIS_FIRST;
        phase_nxt = 1'b0;
        state_nxt = lipm_pkg::ST_AXIS;
      end
      lipm_pkg::ST_AXIS: begin
        cmd.issue = !phase_r;
        cmd.wb    = phase_r;
        phase_nxt = !phase_r;
        if (phase_r) begin
          if (pc_r == lipm_pkg::PC_AXIS_LAST) begin
            if (!axis_r) begin
              axis_nxt = 1'b1;
              pc_nxt   = lipm_pkg::PC_AXIS_FIRST;
            end else begin
              state_nxt = lipm_pkg::ST_EMIT;
            end
          end else begin
            pc_nxt = pc_r + 1'b1;
          end
        end
      end
      lipm_pkg::ST_EMIT: begin
        if (status.slot_free) begin
          cmd.emit = 1'b1;
          if (n_r == NW'(STEPS)) begin
            state_nxt = lipm_pkg::ST_IDLE;
          end else begin
            n_nxt     = n_r + 1'b1;
            state_nxt = lipm_pkg::ST_LEG;
          end
        end
      end
      default: state_nxt = lipm_pkg::ST_IDLE;
    endcase
  end

  assign step_n = n_r;

  // The shared multiplier is never issued back to back.
  a_issue_spaced: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.issue |=> !cmd.issue)
    else $error("multiplier issued in consecutive cycles");

  // A result is only written when the output register can take it.
  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> status.slot_free)
    else $error("result written over a waiting beat");

  // The final step of a horizon returns the controller to idle.
  a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.emit && (n_r == NW'(STEPS))) |=> (state_r == lipm_pkg::ST_IDLE))
    else $error("controller did not finish after the last step");

endmodule

>>> design/lipm_dp.sv
module lipm_dp #(
  parameter int STEPS = lipm_pkg::STEPS_DEF,
  localparam int NW = $clog2(STEPS + 1)
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  lipm_pkg::cmd_t                    cmd,
  input  logic [NW-1:0]                     step_n,
  output lipm_pkg::status_t                 status,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [lipm_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [lipm_pkg::QW-1:0]           cfg_data,
  input  logic                              in_first_step,
  input  logic                              in_support_right,
  input  logic signed [lipm_pkg::QW-1:0]    in_step_forward,
  input  logic signed [lipm_pkg::QW-1:0]    in_step_sideways,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [4:0]                        out_step_index,
  output logic signed [lipm_pkg::QW-1:0]    out_foot_x,
  output logic signed [lipm_pkg::QW-1:0]    out_foot_y,
  output logic signed [lipm_pkg::QW-1:0]    out_com_pos_x,
  output logic signed [lipm_pkg::QW-1:0]    out_com_pos_y,
  output logic signed [lipm_pkg::QW-1:0]    out_com_vel_x,
  output logic signed [lipm_pkg::QW-1:0]    out_com_vel_y,
  output logic                              out_last
);

  localparam int QW = lipm_pkg::QW;

  // Configuration registers.
  logic [QW-1:0] cosh_r, sinh_r, tc_r, itc_r, its_r, idn_r;
  // Request registers.
  logic          first_r, right_r;
  logic [QW-1:0] fwd_r, side_r;
  // Working registers.
  logic [QW-1:0] ts_r, tmp_r, acc_r, prod_r, e_r, t2_r;
  logic [QW-1:0] x0_r [2], v0_r [2], f0_r [2], leg_r [2];
  logic [QW-1:0] xi_r [2], vi_r [2], ft_r [2];
  logic [QW-1:0] cf_r [2], cp_r [2], cv_r [2];
  logic          out_valid_r;

  logic [QW-1:0] kx, ky, omc, w10, k_sel;
  logic [QW-1:0] nx, ny, px, py, p_sel, xe;
  logic [QW-1:0] wx, side_step, first_fy;
  logic [QW-1:0] op_a, op_b, acc_nxt;
  logic signed [2*QW-1:0] prod_full;
  logic          flip;
  logic          ax;

  assign ax = cmd.axis;

  // Constants derived from the cosh term.
  assign kx  = cosh_r + lipm_pkg::Q_ONE;
  assign ky  = cosh_r - lipm_pkg::Q_ONE;
  assign omc = lipm_pkg::Q_ONE - cosh_r;
  assign w10 = (ky << 3) + (ky << 1);
  assign k_sel = ax ? ky : kx;

  // Step lengths and zig-zag end offsets for the current step.
  assign flip = (step_n[0] == !right_r);
  assign nx = (step_n >= NW'(STEPS - 1)) ? '0 : fwd_r;
  assign ny = (step_n == NW'(STEPS)) ? '0 : side_r;
  assign px = lipm_pkg::half_pos(nx);
  assign py = flip ? lipm_pkg::half_pos(ny) : lipm_pkg::half_neg(ny);
  assign p_sel = ax ? py : px;
  assign xe = leg_r[ax] + p_sel;
  assign wx = ((step_n == NW'(STEPS)) || ((step_n == NW'(1)) && first_r)) ? '0 : fwd_r;
  assign side_step = flip ? (QW'(0) - side_r) : side_r;
  assign first_fy = in_support_right ? lipm_pkg::half_neg(in_step_sideways)
                                     : lipm_pkg::half_pos(in_step_sideways);

  // Operand selection for the shared multiplier.
  function automatic logic [QW-1:0] pick(input lipm_pkg::src_t s);
    logic [QW-1:0] v;
    v = '0;
    unique case (s)
      lipm_pkg::SRC_C:   v = cosh_r;
      lipm_pkg::SRC_S:   v = sinh_r;
      lipm_pkg::SRC_TS:  v = ts_r;
      lipm_pkg::SRC_OMC: v = omc;
      lipm_pkg::SRC_K:   v = k_sel;
      lipm_pkg::SRC_W10: v = w10;
      lipm_pkg::SRC_TMP: v = tmp_r;
      lipm_pkg::SRC_TC:  v = tc_r;
      lipm_pkg::SRC_X0:  v = x0_r[ax];
      lipm_pkg::SRC_V0:  v = v0_r[ax];
      lipm_pkg::SRC_F0:  v = f0_r[ax];
      lipm_pkg::SRC_ITC: v = itc_r;
      lipm_pkg::SRC_ITS: v = its_r;
      lipm_pkg::SRC_IDN: v = idn_r;
      lipm_pkg::SRC_P:   v = p_sel;
      lipm_pkg::SRC_XI:  v = xi_r[ax];
      lipm_pkg::SRC_VI:  v = vi_r[ax];
      lipm_pkg::SRC_E:   v = e_r;
      default:           v = '0;
    endcase
    return v;
  endfunction

  assign op_a = pick(cmd.op.src_a);
  assign op_b = pick(cmd.op.src_b);
  assign prod_full = $signed(op_a) * $signed(op_b);

  // Accumulator update in the write-back cycle.
  always_comb begin
    unique case (cmd.op.mode)
      lipm_pkg::MODE_LD:   acc_nxt = prod_r;
      lipm_pkg::MODE_ADD:  acc_nxt = acc_r + prod_r;
      lipm_pkg::MODE_SUB:  acc_nxt = acc_r - prod_r;
      lipm_pkg::MODE_KEEP: acc_nxt = acc_r;
      lipm_pkg::MODE_XE:   acc_nxt = xe - prod_r;
      lipm_pkg::MODE_FT:   acc_nxt = QW'(0) - prod_r - t2_r;
      default:             acc_nxt = acc_r;
    endcase
  end

  // Configuration writes; indexes past the list are ignored.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cosh_r <= lipm_pkg::Q_ONE;
      sinh_r <= '0;
      tc_r   <= '0;
      itc_r  <= '0;
      its_r  <= '0;
      idn_r  <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        lipm_pkg::CFG_COSH:    cosh_r <= cfg_data;
        lipm_pkg::CFG_SINH:    sinh_r <= cfg_data;
        lipm_pkg::CFG_TC:      tc_r   <= cfg_data;
        lipm_pkg::CFG_INV_TC:  itc_r  <= cfg_data;
        lipm_pkg::CFG_INV_TCS: its_r  <= cfg_data;
        lipm_pkg::CFG_INV_DEN: idn_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  assign cfg_ready = 1'b1;

  // Multiplier product, Q8.24 with floor rounding.
  always_ff @(posedge clk) begin
    if (cmd.issue) begin
      prod_r <= prod_full[QW+23:24];
      tmp_r  <= prod_full[QW+23:24];
    end
  end

  // Request load, leg chain, write-back and end-of-step updates.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      first_r <= in_first_step;
      right_r <= in_support_right;
      fwd_r   <= in_step_forward;
      side_r  <= in_step_sideways;
      if (in_first_step) begin
        f0_r[0]  <= '0;
        f0_r[1]  <= first_fy;
        leg_r[0] <= '0;
        leg_r[1] <= first_fy;
        x0_r[0]  <= '0;
        x0_r[1]  <= '0;
        v0_r[0]  <= '0;
        v0_r[1]  <= '0;
      end else begin
        f0_r[0]  <= cf_r[0];
        f0_r[1]  <= cf_r[1];
        leg_r[0] <= cf_r[0];
        leg_r[1] <= cf_r[1];
        x0_r[0]  <= cp_r[0];
        x0_r[1]  <= cp_r[1];
        v0_r[0]  <= cv_r[0];
        v0_r[1]  <= cv_r[1];
      end
    end
    if (cmd.leg) begin
      leg_r[0] <= leg_r[0] + wx;
      leg_r[1] <= leg_r[1] + side_step;
    end
    if (cmd.wb) begin
      acc_r <= acc_nxt;
      unique case (cmd.op.dst)
        lipm_pkg::DST_NONE: ;
        lipm_pkg::DST_TS:   ts_r     <= acc_nxt;
        lipm_pkg::DST_V0:   v0_r[ax] <= acc_nxt;
        lipm_pkg::DST_XI:   xi_r[ax] <= acc_nxt;
        lipm_pkg::DST_VI:   vi_r[ax] <= acc_nxt;
        lipm_pkg::DST_E:    e_r      <= acc_nxt;
        lipm_pkg::DST_T2:   t2_r     <= acc_nxt;
        lipm_pkg::DST_FT:   ft_r[ax] <= acc_nxt;
        default: ;
      endcase
    end
    if (cmd.emit) begin
      for (int a = 0; a < 2; a++) begin
        x0_r[a] <= xi_r[a];
        v0_r[a] <= vi_r[a];
        f0_r[a] <= ft_r[a];
      end
      out_step_index <= 5'(step_n);
      out_foot_x     <= ft_r[0];
      out_foot_y     <= ft_r[1];
      out_com_pos_x  <= xi_r[0];
      out_com_pos_y  <= xi_r[1];
      out_com_vel_x  <= vi_r[0];
      out_com_vel_y  <= vi_r[1];
      out_last       <= (step_n == NW'(STEPS));
    end
  end

  // Step-one carry, cleared by reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int a = 0; a < 2; a++) begin
        cf_r[a] <= '0;
        cp_r[a] <= '0;
        cv_r[a] <= '0;
      end
    end else if (cmd.emit && (step_n == NW'(1))) begin
      for (int a = 0; a < 2; a++) begin
        cf_r[a] <= ft_r[a];
        cp_r[a] <= xi_r[a];
        cv_r[a] <= vi_r[a];
      end
    end
  end

  // Output beat valid flag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_valid        = out_valid_r;
  assign status.slot_free = !out_valid_r || out_ready;
  assign status.first     = first_r;

endmodule

>>> design/lipm_footstep_planner_core.sv
// Channel   Direction  Handshake            Payload
// cfg       in         cfg_valid/cfg_ready  cfg_index, cfg_data
// in        in         in_valid/in_ready    first_step, support_right, step lengths
// out       out        out_valid/out_ready  step index, foot target, CoM state, last
//
// One request gives STEPS result beats. All products go through one shared
// 32x32 multiplier, 20 micro-ops per axis and step, each with an issue phase
// and a write-back phase. Synchronous active-low reset restores the
// configuration defaults and clears the step-one carry. A stalled output
// beat holds the next step.
module lipm_footstep_planner_core #(
  parameter int STEPS = lipm_pkg::STEPS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [lipm_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [lipm_pkg::QW-1:0]           cfg_data,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic                              in_first_step,
  input  logic                              in_support_right,
  input  logic signed [lipm_pkg::QW-1:0]    in_step_forward,
  input  logic signed [lipm_pkg::QW-1:0]    in_step_sideways,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [4:0]                        out_step_index,
  output logic signed [lipm_pkg::QW-1:0]    out_foot_x,
  output logic signed [lipm_pkg::QW-1:0]    out_foot_y,
  output logic signed [lipm_pkg::QW-1:0]    out_com_pos_x,
  output logic signed [lipm_pkg::QW-1:0]    out_com_pos_y,
  output logic signed [lipm_pkg::QW-1:0]    out_com_vel_x,
  output logic signed [lipm_pkg::QW-1:0]    out_com_vel_y,
  output logic                              out_last
);

  localparam int NW = $clog2(STEPS + 1);

  lipm_pkg::cmd_t    cmd;
  lipm_pkg::status_t status;
  logic [NW-1:0]     step_n;

  // Sequencer.
  lipm_ctrl #(.STEPS(STEPS)) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd),
    .step_n   (step_n)
  );

  // Arithmetic and state.
  lipm_dp #(.STEPS(STEPS)) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .step_n           (step_n),
    .status           (status),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_first_step    (in_first_step),
    .in_support_right (in_support_right),
    .in_step_forward  (in_step_forward),
    .in_step_sideways (in_step_sideways),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_step_index   (out_step_index),
    .out_foot_x       (out_foot_x),
    .out_foot_y       (out_foot_y),
    .out_com_pos_x    (out_com_pos_x),
    .out_com_pos_y    (out_com_pos_y),
    .out_com_vel_x    (out_com_vel_x),
    .out_com_vel_y    (out_com_vel_y),
    .out_last         (out_last)
  );

endmodule
